[design/rbd_pkg.sv]
// Shared constants for the 2x2 RGBA box downsampler.
// Used by the channel lane, the line buffer and the top level.
// No dependencies.
package rbd_pkg;

  // Pixel layout: four 8-bit channels, channel 0 in the low byte.
  localparam int unsigned NumCh  = 4;
  localparam int unsigned ChW    = 8;
  localparam int unsigned PixW   = NumCh * ChW;
  // A pair sum of one channel is held with two more bits than a channel.
  localparam int unsigned SumW   = ChW + 2;
  localparam int unsigned PairW  = NumCh * SumW;

  // Configuration register layout.
  localparam int unsigned DimW   = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  // Frame geometry limits.
  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned HeightLimit     = 4096;
  localparam int unsigned RowW            = 12;
  localparam int unsigned MinDim          = 2;

endpackage

[design/rbd_lane.sv]
// One channel lane of the 2x2 box downsampler: horizontal pair sum and
// rounded block mean of one 8-bit channel.
// Depends on rbd_pkg.
module rbd_lane
  import rbd_pkg::*;
(
  input  logic [ChW-1:0]  left_i,
  input  logic [ChW-1:0]  right_i,
  input  logic [SumW-1:0] top_i,
  input  logic [SumW-1:0] bottom_i,
  output logic [SumW-1:0] pair_o,
  output logic [ChW-1:0]  mean_o
);

  logic [SumW:0] block_sum;

  // Sum of the two horizontally adjacent samples.
  assign pair_o = SumW'(left_i) + SumW'(right_i);

  // Four samples plus two, divided by four; the result keeps the low byte.
  assign block_sum = (SumW + 1)'(top_i) + (SumW + 1)'(bottom_i) + (SumW + 1)'(2);
  assign mean_o    = block_sum[ChW+1:2];

endmodule

[design/rbd_line_buf.sv]
// Line buffer holding the pair sums of the even row of each row pair.
// One write port and one read port with registered read data.
// Depends on rbd_pkg.
module rbd_line_buf
  import rbd_pkg::*;
#(
  parameter int unsigned Depth = MaxWidthDefault / 2,
  parameter int unsigned AddrW = $clog2(MaxWidthDefault / 2)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [PairW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [PairW-1:0] rd_data_o
);

  logic [PairW-1:0] mem_q [Depth];
  logic [PairW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/rgba_box_downsample_2x2.sv]
// Top level of the 2x2 RGBA box downsampler.
// Depends on rbd_pkg, rbd_lane and rbd_line_buf.
//
// Usage:
//   The slave stream carries one RGBA pixel per item in raster order, frame
//   after frame with no gap. The master stream carries one averaged pixel for
//   each complete 2x2 block; tlast marks the last averaged pixel of a frame.
//   An odd last column and an odd last row of a frame produce no output.
//   The configuration port sets the frame width and height (clamped to at
//   least 2, at most MAX_WIDTH columns and 4096 rows). A write restarts the
//   frame at its top-left pixel; write only while the block is idle.
// Timing:
//   One pixel is accepted per cycle while tready is high. A block's result
//   is registered in the read stage with the line buffer read when its
//   bottom-right pixel is accepted, and its means in the output register.
// Reset and stall:
//   Reset sets a 2x2 frame and the top-left position; the line buffer needs
//   no clearing, since each entry is written on an even row before the odd
//   row of the same frame reads it. When the receiver stalls, the output
//   register holds, the pending block waits in the read stage and tready
//   drops only once both are full.
module rgba_box_downsample_2x2
  import rbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  // Input pixel stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [PixW-1:0]    s_axis_tdata_i,   // [31:0] pixel_in
  // Output pixel stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [PixW-1:0]    m_axis_tdata_o,   // [31:0] pixel_out
  output logic               m_axis_tlast_o    // frame_last
);

  localparam int unsigned ColW      = $clog2(MAX_WIDTH);
  localparam int unsigned LineDepth = MAX_WIDTH / 2;
  localparam int unsigned LineAw    = $clog2(LineDepth);
  localparam int unsigned ExtW      = (ColW + 1 > DimW) ? ColW + 1 : DimW;

  // Geometry derived from the configuration.
  logic [ColW-1:0] col_max_q, col_max_d, col_last_q, col_last_d;
  logic [RowW-1:0] row_max_q, row_max_d, row_last_q, row_last_d;
  logic [ExtW-1:0] w_ext, w_eff;
  logic [DimW-1:0] h_eff;

  // Position and left pixel of the current pair.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] left_q, left_d;

  // Read stage and output register.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_last_q;
  logic [PairW-1:0] s1_pair_q;
  logic             out_valid_q, out_valid_d;
  logic [PixW-1:0]  out_data_q;
  logic             out_last_q;

  logic             in_acc, out_adv, s1_move;
  logic             odd_col, odd_row, wr_line, rd_line, blk_last;
  logic [LineAw-1:0] line_addr;
  logic [PairW-1:0] pair_now, pair_top;
  logic [PixW-1:0]  mean_now;
  logic [PairW-1:0] lane_unused;

  // Handshake: the output register frees when taken, the read stage moves on.
  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s1_move         = s1_valid_q && out_adv;
  assign s_axis_tready_o = !s1_valid_q || out_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign wr_line   = in_acc && odd_col && !odd_row;
  assign rd_line   = in_acc && odd_col && odd_row;
  assign line_addr = col_q[LineAw:1];
  assign blk_last  = (col_q == col_last_q) && (row_q == row_last_q);

  // Clamp written dimensions and derive the wrap and last-block positions.
  always_comb begin
    w_ext = ExtW'(cfg_wdata_i);
    if (w_ext < ExtW'(MinDim)) begin
      w_eff = ExtW'(MinDim);
    end else if (w_ext > ExtW'(MAX_WIDTH)) begin
      w_eff = ExtW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (cfg_wdata_i < DimW'(MinDim)) begin
      h_eff = DimW'(MinDim);
    end else if (cfg_wdata_i > DimW'(HeightLimit)) begin
      h_eff = DimW'(HeightLimit);
    end else begin
      h_eff = cfg_wdata_i;
    end
    col_max_d  = col_max_q;
    col_last_d = col_last_q;
    row_max_d  = row_max_q;
    row_last_d = row_last_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth: begin
          col_max_d  = ColW'(w_eff - ExtW'(1));
          col_last_d = ColW'({w_eff[ExtW-1:1], 1'b0} - ExtW'(1));
        end
        RegImageHeight: begin
          row_max_d  = RowW'(h_eff - DimW'(1));
          row_last_d = RowW'({h_eff[DimW-1:1], 1'b0} - DimW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position, left pixel hold and pipeline valid bits.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    s1_valid_d  = s1_move ? 1'b0 : s1_valid_q;
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
    if (in_acc) begin
      if (!odd_col) begin
        left_d = s_axis_tdata_i;
      end
      if (col_q == col_max_q) begin
        col_d = '0;
        row_d = (row_q == row_max_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
      if (rd_line) begin
        s1_valid_d = 1'b1;
      end
    end
    if (cfg_we_i) begin
      col_d  = '0;
      row_d  = '0;
      left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_max_q   <= ColW'(1);
      col_last_q  <= ColW'(1);
      row_max_q   <= RowW'(1);
      row_last_q  <= RowW'(1);
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_max_q   <= col_max_d;
      col_last_q  <= col_last_d;
      row_max_q   <= row_max_d;
      row_last_q  <= row_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers of the read stage and the output.
  always_ff @(posedge clk_i) begin
    if (rd_line) begin
      s1_pair_q <= pair_now;
      s1_last_q <= blk_last;
    end
    if (s1_move) begin
      out_data_q <= mean_now;
      out_last_q <= s1_last_q;
    end
  end

  // Channel lanes: pair sums of the incoming pair, means of the pending block.
  for (genvar ch = 0; ch < NumCh; ch++) begin : g_lane
    rbd_lane u_pair_lane (
      .left_i   (left_q[ch*ChW +: ChW]),
      .right_i  (s_axis_tdata_i[ch*ChW +: ChW]),
      .top_i    (pair_top[ch*SumW +: SumW]),
      .bottom_i (s1_pair_q[ch*SumW +: SumW]),
      .pair_o   (pair_now[ch*SumW +: SumW]),
      .mean_o   (mean_now[ch*ChW +: ChW])
    );
    assign lane_unused[ch*SumW +: SumW] = '0;
  end

  rbd_line_buf #(
    .Depth (LineDepth),
    .AddrW (LineAw)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_line),
    .wr_addr_i (line_addr),
    .wr_data_i (pair_now | lane_unused),
    .rd_en_i   (rd_line),
    .rd_addr_i (line_addr),
    .rd_data_o (pair_top)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
